// ===== rtl/json_string_unescape_utf8_defines.svh =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_defines
// Assertion macros shared by the unescaper RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define JSU_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// antecedent implies consequent in the next cycle
`define JSU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

// expression never true
`define JSU_ASSERT_NEVER(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
        else $error("jsu assertion failed");

`endif

// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared by the unescaper front, queue and back.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // most output bytes one input byte can cause
    localparam int GrpSlots = 5;

    // all results of one input byte
    typedef struct packed {
        logic [GrpSlots-1:0][7:0] data;
        logic [2:0]               count;  // 1..5 when queued
        logic                     eos;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/json_string_unescape_utf8.sv =====
// An accepted beat's group is queued, then loaded into the output register.
// Throughput: one input beat per cycle while the group queue has room; the
// output side gives one beat per cycle while out_stall is low, so the queue
// absorbs multi-byte bursts while the serializer emits a group beat by beat.
// Reset: rst_n async low; escape state, queue pointers and output valid clear.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper with UTF-8 encoding of backslash-u escapes.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QDEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       string_done,
    output logic       run_last
);

    // Front: decodes the escape state machine and builds the whole group of
    // results for a byte in the accept cycle. Bytes that cause no result
    // (backslash, escape u, hex digits being gathered) only update state.
    // Queue: holds groups so the front keeps taking one beat per cycle, while
    // the queue has room, as the back works through a long group.
    // Back: emits a group one beat at a time into a registered output stage.

    logic      accept;
    logic      push, pop;
    group_t    front_group, head;
    q_status_t qstat;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    jsu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .push          (push),
        .group         (front_group)
    );

    jsu_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_group (front_group),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .stat        (qstat),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .string_done (string_done),
        .run_last    (run_last)
    );

endmodule

// ===== rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: tracks escape state and turns each byte into a group.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output logic       push,
    output group_t     group
);

    typedef enum logic [2:0] {
        NORMAL = 3'd0,
        ESC    = 3'd1,
        HEX0   = 3'd2,
        HEX1   = 3'd3,
        HEX2   = 3'd4,
        HEX3   = 3'd5
    } mode_t;

    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChBsl   = 8'h5C;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChB     = 8'h62;
    localparam logic [7:0] ChF     = 8'h66;
    localparam logic [7:0] ChN     = 8'h6E;
    localparam logic [7:0] ChR     = 8'h72;
    localparam logic [7:0] ChT     = 8'h74;
    localparam logic [7:0] ChU     = 8'h75;

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  held_reg [3];

    logic        hv_ok;
    logic [3:0]  hv;
    logic [1:0]  cnt;
    logic [15:0] cp;
    logic        plain_emit;
    logic        store;

    always_comb
    begin
        hv_ok = 1'b1;
        hv    = in_byte[3:0];
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            hv = in_byte[3:0];
        end
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
        begin
            hv = 4'(in_byte[3:0] + 4'd9);
        end
        else
        begin
            hv_ok = 1'b0;
        end
    end

    assign cnt        = 2'(mode_reg - HEX0);
    assign cp         = {acc_reg[11:0], hv};
    assign plain_emit = !(in_byte == ChBsl && !end_of_string);

    always_comb
    begin
        group.data  = {GrpSlots{in_byte}};
        group.count = 3'd0;
        group.eos   = end_of_string;
        mode_next   = NORMAL;
        store       = 1'b0;

        unique case (mode_reg) inside
            ESC:
            begin
                group.count = 3'd1;
                case (in_byte)
                    ChQuote: group.data[0] = ChQuote;
                    ChBsl:   group.data[0] = ChBsl;
                    ChSlash: group.data[0] = ChSlash;
                    ChB:     group.data[0] = 8'h08;
                    ChF:     group.data[0] = 8'h0C;
                    ChN:     group.data[0] = 8'h0A;
                    ChR:     group.data[0] = 8'h0D;
                    ChT:     group.data[0] = 8'h09;
                    ChU:
                    begin
                        group.data[0] = ChU;
                        if (!end_of_string)
                        begin
                            group.count = 3'd0;
                            mode_next   = HEX0;
                        end
                    end
                    default:
                    begin
                        group.data[0] = ChBsl;
                        group.count   = 3'd2;
                    end
                endcase
            end
            HEX0, HEX1, HEX2, HEX3:
            begin
                // 'u', held digits, then the current byte
                group.data[0] = ChU;
                group.data[1] = (cnt >= 2'd1) ? held_reg[0] : in_byte;
                group.data[2] = (cnt >= 2'd2) ? held_reg[1] : in_byte;
                group.data[3] = (cnt == 2'd3) ? held_reg[2] : in_byte;
                if (hv_ok && cnt == 2'd3)
                begin
                    if (cp[15:7] == 9'd0)
                    begin
                        group.data[0] = cp[7:0];
                        group.count   = 3'd1;
                    end
                    else if (cp[15:11] == 5'd0)
                    begin
                        group.data[0] = 8'hC0 | {3'd0, cp[10:6]};
                        group.data[1] = 8'h80 | {2'd0, cp[5:0]};
                        group.count   = 3'd2;
                    end
                    else
                    begin
                        group.data[0] = 8'hE0 | {4'd0, cp[15:12]};
                        group.data[1] = 8'h80 | {2'd0, cp[11:6]};
                        group.data[2] = 8'h80 | {2'd0, cp[5:0]};
                        group.count   = 3'd3;
                    end
                end
                else if (hv_ok && end_of_string)
                begin
                    group.count = 3'({1'b0, cnt} + 3'd2);
                end
                else if (hv_ok)
                begin
                    store     = 1'b1;
                    mode_next = mode_t'(3'(mode_reg + 3'd1));
                end
                else
                begin
                    // short escape: flush, then treat byte as plain
                    group.count = 3'({1'b0, cnt} + 3'd1 + {2'd0, plain_emit});
                    mode_next   = plain_emit ? NORMAL : ESC;
                end
            end
            default:
            begin
                group.count = {2'd0, plain_emit};
                mode_next   = plain_emit ? NORMAL : ESC;
            end
        endcase

        if (end_of_string)
        begin
            mode_next = NORMAL;
        end
        acc_next = store ? cp : 16'd0;
    end

    assign push = accept && (group.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= NORMAL;
            acc_reg  <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store)
        begin
            held_reg[cnt] <= in_byte;
        end
    end

    `JSU_ASSERT_NEXT(a_eos_resets_mode, clk, rst_n, accept && end_of_string, mode_reg == NORMAL)

endmodule

// ===== rtl/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Short FIFO of result groups between decoder and serializer.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  group_t    wr_group,
    input  logic      pop,
    output group_t    head,
    output q_status_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    group_t          entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= CW'(cnt_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= CW'(cnt_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_group;
        end
    end

    `JSU_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && stat.full)
    `JSU_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && stat.empty)

endmodule

// ===== rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Serializer: walks the head group, one output beat per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module jsu_back
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  group_t    head,
    input  q_status_t stat,
    output logic      pop,
    input  logic      out_stall,
    output logic      out_valid,
    output logic [7:0] out_byte,
    output logic      string_done,
    output logic      run_last
);

    logic [2:0] k_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       done_reg, last_reg;
    logic       load, last;

    assign load = !stat.empty && (!valid_reg || !out_stall);
    assign last = (k_reg == 3'(head.count - 3'd1));
    assign pop  = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                k_reg     <= last ? 3'd0 : 3'(k_reg + 3'd1);
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.data[k_reg];
            last_reg <= last;
            done_reg <= last && head.eos;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign string_done = done_reg;
    assign run_last    = last_reg;

    `JSU_ASSERT_NEXT(a_idx_rewind, clk, rst_n, pop, k_reg == 3'd0)

endmodule
